/* rtl/core/crcfp_pkg.sv */
// Shared types, codes and CRC-32 table functions for the forcing patch block.
`timescale 1ns / 1ps
package crcfp_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_TOP_BIT = 32'h80000000;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_FRONT  = 2'd0;
    localparam t_func FUNC_BEHIND = 2'd1;
    localparam t_func FUNC_FINISH = 2'd2;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
    } t_item;

    // Forward table entry: eight reflected shift steps of the byte.
    function automatic logic [31:0] crc_fwd_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Reverse table entry: undoes eight forward shifts keyed by the top byte.
    function automatic logic [31:0] crc_rev_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {idx, 24'd0};
        for (int k = 0; k < 8; k++) begin
            v = ((v & CRC_TOP_BIT) != 32'd0) ? (((v ^ CRC_POLY) << 1) | 32'd1) : (v << 1);
        end
        return v;
    endfunction

    function automatic logic [31:0] crc_fwd_step(input logic [31:0] crc, input logic [7:0] b);
        return (crc >> 8) ^ crc_fwd_entry(crc[7:0] ^ b);
    endfunction

    function automatic logic [31:0] crc_back_step(input logic [31:0] crc, input logic [7:0] b);
        return (crc << 8) ^ crc_rev_entry(crc[31:24]) ^ {24'd0, b};
    endfunction

endpackage

/* rtl/core/crcfp_in_reg.sv */
// Input register stage that holds one accepted beat until the engine takes it.
`timescale 1ns / 1ps
module crcfp_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_func,
    input  logic [7:0]     i_data_byte,
    output logic           o_in_ready,
    input  logic           i_take,
    output logic           o_valid,
    output crcfp_pkg::t_item o_item
);
    import crcfp_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.func <= i_func;
            r_item.data <= i_data_byte;
        end
    end

endmodule

/* rtl/core/crcfp_engine.sv */
// CRC state registers and the forward, backward and finish step logic.
`timescale 1ns / 1ps
module crcfp_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_valid,
    input  crcfp_pkg::t_item i_item,
    input  logic             i_slot_free,
    output logic             o_take,
    output logic             o_res_valid,
    output logic [31:0]      o_res_word
);
    import crcfp_pkg::*;

    logic [31:0] r_target;
    logic [31:0] r_fwd;
    logic [31:0] r_bwd;
    logic        r_started;

    logic [31:0] n_fwd;
    logic [31:0] n_bwd;
    logic        n_started;
    logic [31:0] bwd_base;
    logic [31:0] fin_word;

    // The backward register is loaded from the target on its first use.
    assign bwd_base = r_started ? r_bwd : (r_target ^ CRC_ONES);

    // A finish beat waits only when the result register cannot take its word.
    assign o_take      = i_valid && ((i_item.func != FUNC_FINISH) || i_slot_free);
    assign o_res_valid = o_take && (i_item.func == FUNC_FINISH);
    assign o_res_word  = fin_word;

    always_comb begin
        fin_word = bwd_base;
        for (int k = 3; k >= 0; k--) begin
            fin_word = crc_back_step(fin_word, r_fwd[8*k +: 8]);
        end
    end

    always_comb begin
        n_fwd     = r_fwd;
        n_bwd     = r_bwd;
        n_started = r_started;
        unique case (i_item.func)
            FUNC_FRONT: begin
                n_fwd = crc_fwd_step(r_fwd, i_item.data);
            end
            FUNC_BEHIND: begin
                n_bwd     = crc_back_step(bwd_base, i_item.data);
                n_started = 1'b1;
            end
            FUNC_FINISH: begin
                n_fwd     = CRC_ONES;
                n_started = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 32'd0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd     <= CRC_ONES;
            r_started <= 1'b0;
        end else if (o_take) begin
            r_fwd     <= n_fwd;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bwd <= n_bwd;
        end
    end

endmodule

/* rtl/core/crcfp_out_reg.sv */
// Result register that holds one patch word until the consumer takes it.
`timescale 1ns / 1ps
module crcfp_out_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_word,
    output logic        o_slot_free,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_patch_word
);
    logic        r_valid;
    logic [31:0] r_word;

    assign o_slot_free  = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_patch_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

/* rtl/core/crc32_forcing_patch_top.sv */
// Top level of the CRC-32 forcing patch generator.
// A finish beat's patch word is built combinationally and registered as it is taken.
// Throughput: one beat per cycle unless a finish beat waits on a full result register;
// the byte beat's table step and the four chained reverse-table steps are combinational.
// Reset (synchronous, active low) sets the target to zero, the forward CRC to
// all ones, clears the backward-started flag and empties both beat registers.
`timescale 1ns / 1ps
module crc32_forcing_patch_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_patch_word
);
    import crcfp_pkg::*;

    // The input register decouples the upstream handshake from the engine:
    // a beat moves on whenever the engine takes it, so byte beats keep
    // flowing even while a finished patch word waits in the result register.
    logic        stg_valid;
    t_item       stg_item;
    logic        take;
    logic        slot_free;
    logic        res_valid;
    logic [31:0] res_word;

    crcfp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_in_ready  (o_in_ready),
        .i_take      (take),
        .o_valid     (stg_valid),
        .o_item      (stg_item)
    );

    // The engine owns the target, forward and backward CRC registers. Only a
    // finish beat can stall, and only when the result register is still full.
    crcfp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stg_valid),
        .i_item      (stg_item),
        .i_slot_free (slot_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res_word  (res_word)
    );

    // The result register frees its slot in the same cycle its beat is taken,
    // so back-to-back finish beats also run at full rate while the consumer is ready.
    crcfp_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_valid),
        .i_word       (res_word),
        .o_slot_free  (slot_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_patch_word (o_patch_word)
    );

endmodule
